[hdl/cap_select_shift_out_sequencer_assert.svh]
// Assertion macros used by the sequencer RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef CAP_SELECT_SHIFT_OUT_SEQUENCER_ASSERT_SVH
`define CAP_SELECT_SHIFT_OUT_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSSO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CSSO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CSSO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define CSSO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/csso_pkg.sv]
`default_nettype none

package csso_pkg;

   localparam int FUNC_BITS      = 2;
   localparam int CHAN_NUM_BITS  = 3;
   localparam int CAP_VALUE_BITS = 8;
   localparam int EN_BITS        = 4;
   localparam int PW_BITS        = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int NUM_WIDTH_REGS = 4;
   localparam int WIDTH_IDX_BITS = 2;

   // Command codes carried in the func field.
   typedef enum logic [FUNC_BITS-1:0] {
      CMD_SET     = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_START   = 2'd2
   } cmd_type;

   // One decoded command waiting for the sequencer.
   typedef struct packed {
      logic               is_load;
      logic [EN_BITS-1:0] chan_enable;
      logic [PW_BITS-1:0] pulse_width;
      logic               pwm_start;
   } job_type;

endpackage

`default_nettype wire

[hdl/csso_if.sv]
`default_nettype none

interface csso_req_if;
   logic                                valid;
   logic                                ready;
   logic [csso_pkg::FUNC_BITS-1:0]      func;
   logic [csso_pkg::CHAN_NUM_BITS-1:0]  chan_num;
   logic [csso_pkg::CAP_VALUE_BITS-1:0] cap_value;

   modport source (output valid, func, chan_num, cap_value, input ready);
   modport sink   (input valid, func, chan_num, cap_value, output ready);
endinterface

interface csso_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic                         ser_bit;
   logic                         shift_clk;
   logic                         latch_clk;
   logic                         clear_n;
   logic                         out_enable_n;
   logic [csso_pkg::EN_BITS-1:0] chan_enable;
   logic [csso_pkg::PW_BITS-1:0] pulse_width;
   logic                         pwm_start;
   logic                         last;

   modport source (output valid, kind, ser_bit, shift_clk, latch_clk, clear_n,
                   out_enable_n, chan_enable, pulse_width, pwm_start, last,
                   input ready);
   modport sink   (input valid, kind, ser_bit, shift_clk, latch_clk, clear_n,
                   out_enable_n, chan_enable, pulse_width, pwm_start, last,
                   output ready);
endinterface

interface csso_csr_if;
   logic                                valid;
   logic                                ready;
   logic [csso_pkg::CSR_INDEX_BITS-1:0] index;
   logic [csso_pkg::PW_BITS-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/csso_cmd.sv]
`default_nettype none

module csso_cmd #(
   parameter int NUM_CHANNELS = 4,
   parameter int FIELD_BITS   = 6,
   parameter int SHIFT_BITS   = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_fire,
   input  wire logic [csso_pkg::FUNC_BITS-1:0]      func,
   input  wire logic [csso_pkg::CHAN_NUM_BITS-1:0]  chan_num,
   input  wire logic [csso_pkg::CAP_VALUE_BITS-1:0] cap_value,
   input  wire logic                                csr_fire,
   input  wire logic [csso_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [csso_pkg::PW_BITS-1:0]        csr_data,
   output      logic                                job_push,
   output      csso_pkg::job_type                   job,
   output      logic [SHIFT_BITS-1:0]               job_shadow
);

   localparam int ACW  = $clog2(NUM_CHANNELS);
   localparam int WIDE = SHIFT_BITS + NUM_CHANNELS * FIELD_BITS;

   logic [SHIFT_BITS-1:0]          shadow_ff;
   logic [ACW-1:0]                 active_ff;
   logic [csso_pkg::PW_BITS-1:0]   width_ff [csso_pkg::NUM_WIDTH_REGS];

   csso_pkg::cmd_type              cmd;
   logic                           chan_ok;
   logic                           has_result;
   logic                           is_set;
   logic                           is_advance;
   logic                           is_start;
   logic [ACW-1:0]                 adv_chan;
   logic [ACW-1:0]                 sel_chan;
   logic [csso_pkg::CHAN_NUM_BITS-1:0] sel_ext;
   logic [FIELD_BITS-1:0]          val_field;
   logic [SHIFT_BITS-1:0]          merged;

   assign cmd       = csso_pkg::cmd_type'(func);
   assign val_field = cap_value[FIELD_BITS-1:0];

   always_comb begin
      chan_ok  = (chan_num != '0) && (int'(chan_num) <= NUM_CHANNELS);
      adv_chan = (active_ff == ACW'(NUM_CHANNELS - 1)) ? '0 : active_ff + ACW'(1);
      has_result = 1'b0;
      is_set     = 1'b0;
      is_advance = 1'b0;
      is_start   = 1'b0;
      unique case (cmd)
         csso_pkg::CMD_SET: begin
            has_result = chan_ok;
            is_set     = chan_ok;
         end
         csso_pkg::CMD_ADVANCE: begin
            has_result = 1'b1;
            is_advance = 1'b1;
         end
         csso_pkg::CMD_START: begin
            has_result = 1'b1;
            is_start   = 1'b1;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // Channel index reported by an update: the new one after an advance.
   always_comb begin
      sel_chan = is_advance ? adv_chan : active_ff;
      sel_ext  = csso_pkg::CHAN_NUM_BITS'(sel_chan);
      job.is_load   = is_set;
      job.pwm_start = is_start;
      if (int'(sel_ext) < csso_pkg::EN_BITS) begin
         job.chan_enable = csso_pkg::EN_BITS'(1) << sel_ext;
      end else begin
         job.chan_enable = '0;
      end
      if (int'(sel_ext) < csso_pkg::NUM_WIDTH_REGS) begin
         job.pulse_width = width_ff[sel_ext[csso_pkg::WIDTH_IDX_BITS-1:0]];
      end else begin
         job.pulse_width = '0;
      end
   end

   // Channel 1 owns the top field; bits of a field that fall above the
   // shadow word are dropped.
   always_comb begin
      logic [WIDE-1:0] val_wide;
      logic [WIDE-1:0] mask_wide;
      merged    = shadow_ff;
      val_wide  = '0;
      mask_wide = '0;
      for (int c = 1; c <= NUM_CHANNELS; c++) begin
         if (int'(chan_num) == c) begin
            val_wide  = WIDE'(val_field) << ((NUM_CHANNELS - c) * FIELD_BITS);
            mask_wide = WIDE'({FIELD_BITS{1'b1}}) << ((NUM_CHANNELS - c) * FIELD_BITS);
            merged    = (shadow_ff & ~mask_wide[SHIFT_BITS-1:0]) |
                        val_wide[SHIFT_BITS-1:0];
         end
      end
   end

   assign job_push   = req_fire && has_result;
   assign job_shadow = merged;

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff <= '0;
         active_ff <= '0;
      end else if (req_fire) begin
         if (is_set) begin
            shadow_ff <= merged;
         end
         if (is_advance) begin
            active_ff <= adv_chan;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '{default: '0};
      end else if (csr_fire &&
                   (csr_index < csso_pkg::CSR_INDEX_BITS'(csso_pkg::NUM_WIDTH_REGS))) begin
         width_ff[csr_index[csso_pkg::WIDTH_IDX_BITS-1:0]] <= csr_data;
      end
   end

endmodule

`default_nettype wire

[hdl/csso_seq.sv]
`default_nettype none

`include "cap_select_shift_out_sequencer_assert.svh"

module csso_seq #(
   parameter int SHIFT_BITS = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_push,
   input  wire csso_pkg::job_type            job,
   input  wire logic [SHIFT_BITS-1:0]        job_shadow,
   output      logic                         slot_free,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_valid,
   output      logic                         rsp_kind,
   output      logic                         rsp_ser_bit,
   output      logic                         rsp_shift_clk,
   output      logic                         rsp_latch_clk,
   output      logic [csso_pkg::EN_BITS-1:0] rsp_chan_enable,
   output      logic [csso_pkg::PW_BITS-1:0] rsp_pulse_width,
   output      logic                         rsp_pwm_start,
   output      logic                         rsp_last
);

   localparam int NSTEP = 2 * SHIFT_BITS + 2;
   localparam int CW    = $clog2(NSTEP);
   localparam logic [CW-1:0] LATCH_STEP = CW'(2 * SHIFT_BITS);
   localparam logic [CW-1:0] LAST_STEP  = CW'(2 * SHIFT_BITS + 1);

   // Queued command.
   logic                  job_valid_ff, job_valid_in;
   csso_pkg::job_type     job_ff;
   logic [SHIFT_BITS-1:0] jshadow_ff;

   // Command in progress.
   logic                  busy_ff, busy_in;
   csso_pkg::job_type     bjob_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [SHIFT_BITS-1:0] sh_ff, sh_in;

   // Output register.
   logic                         rsp_valid_ff;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic                         rsp_ser_ff, rsp_ser_in;
   logic                         rsp_sclk_ff, rsp_sclk_in;
   logic                         rsp_latch_ff, rsp_latch_in;
   logic [csso_pkg::EN_BITS-1:0] rsp_en_ff, rsp_en_in;
   logic [csso_pkg::PW_BITS-1:0] rsp_pw_ff, rsp_pw_in;
   logic                         rsp_start_ff, rsp_start_in;
   logic                         rsp_last_ff, rsp_last_in;

   csso_pkg::job_type     cur_job;
   logic [CW-1:0]         cur_cnt;
   logic [SHIFT_BITS-1:0] cur_sh;
   logic                  cur_valid;
   logic                  out_load;
   logic                  emit;
   logic                  job_pop;

   assign cur_valid = busy_ff || job_valid_ff;
   assign cur_job   = busy_ff ? bjob_ff : job_ff;
   assign cur_cnt   = busy_ff ? cnt_ff : '0;
   assign cur_sh    = busy_ff ? sh_ff : jshadow_ff;
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign emit      = out_load && cur_valid;
   assign job_pop   = emit && !busy_ff;
   assign slot_free = !job_valid_ff || job_pop;

   always_comb begin
      rsp_ser_in   = 1'b0;
      rsp_sclk_in  = 1'b0;
      rsp_latch_in = 1'b0;
      rsp_en_in    = '0;
      rsp_pw_in    = '0;
      rsp_start_in = 1'b0;
      if (cur_job.is_load) begin
         rsp_kind_in = 1'b0;
         if (cur_cnt < LATCH_STEP) begin
            rsp_ser_in  = cur_sh[0];
            rsp_sclk_in = cur_cnt[0];
         end
         rsp_latch_in = (cur_cnt == LATCH_STEP);
         rsp_last_in  = (cur_cnt == LAST_STEP);
      end else begin
         rsp_kind_in  = 1'b1;
         rsp_en_in    = cur_job.chan_enable;
         rsp_pw_in    = cur_job.pulse_width;
         rsp_start_in = cur_job.pwm_start;
         rsp_last_in  = 1'b1;
      end
      busy_in      = emit ? !rsp_last_in : busy_ff;
      cnt_in       = cur_cnt + CW'(1);
      sh_in        = cur_cnt[0] ? (cur_sh >> 1) : cur_sh;
      job_valid_in = job_push || (job_valid_ff && !job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         busy_ff      <= busy_in;
         if (emit) begin
            cnt_ff <= cnt_in;
         end
         if (out_load) begin
            rsp_valid_ff <= cur_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_push) begin
         job_ff     <= job;
         jshadow_ff <= job_shadow;
      end
      if (emit) begin
         bjob_ff      <= cur_job;
         sh_ff        <= sh_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_ser_ff   <= rsp_ser_in;
         rsp_sclk_ff  <= rsp_sclk_in;
         rsp_latch_ff <= rsp_latch_in;
         rsp_en_ff    <= rsp_en_in;
         rsp_pw_ff    <= rsp_pw_in;
         rsp_start_ff <= rsp_start_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_ser_bit     = rsp_ser_ff;
   assign rsp_shift_clk   = rsp_sclk_ff;
   assign rsp_latch_clk   = rsp_latch_ff;
   assign rsp_chan_enable = rsp_en_ff;
   assign rsp_pulse_width = rsp_pw_ff;
   assign rsp_pwm_start   = rsp_start_ff;
   assign rsp_last        = rsp_last_ff;

   `CSSO_ASSERT_NOW(a_cnt_range, clock, reset, busy_ff, cnt_ff <= LAST_STEP, "step count past end")
   `CSSO_ASSERT_NOW(a_busy_load, clock, reset, busy_ff, bjob_ff.is_load, "update left busy set")
   `CSSO_ASSERT_NEXT(a_latch_then_last, clock, reset, rsp_valid_ff && rsp_latch_ff && rsp_ready, rsp_valid_ff && rsp_last_ff, "latch beat not followed by final beat")
   `CSSO_ASSERT_NEXT(a_job_kept, clock, reset, job_valid_ff && !job_pop, job_valid_ff, "queued command lost")

endmodule

`default_nettype wire

[hdl/cap_select_shift_out_sequencer.sv]
// Capacitor-select shift-out sequencer.
// req_if takes one command per beat: set a channel's capacitor field, advance
// to the next channel, or start PWM on the current one. csr_if writes the four
// per-channel pulse widths; it is always ready, and the user must use it only
// while idle; the block does not enforce this. rsp_if returns the result
// beats: a valid set gives 2*SHIFT_BITS+2 pin-state beats (50 by default),
// advance and start give one channel-update beat, and a set to a channel
// outside 1..NUM_CHANNELS or an unused code gives none. The first beat of a
// command passes through the queue register and then the output register
// before it is valid on the output. The step counter emits one beat per
// cycle while the receiver does not stall. One more command is held in a
// queue register, so a command is accepted while the previous one is still
// shifting out or its last beat still waits in the output register.
// Reset clears the shadow word, selects channel 1 and zeroes the widths.
// When the receiver stalls, the output register holds its beat and the
// sequencer freezes; the input side stalls once the queue register is full.
`default_nettype none

module cap_select_shift_out_sequencer #(
   parameter int NUM_CHANNELS = 4,
   parameter int FIELD_BITS   = 6,
   parameter int SHIFT_BITS   = 24
) (
   input wire logic  clock,
   input wire logic  reset,
   csso_req_if.sink  req_if,
   csso_rsp_if.source rsp_if,
   csso_csr_if.sink  csr_if
);

   logic                  req_fire;
   logic                  csr_fire;
   logic                  job_push;
   csso_pkg::job_type     job;
   logic [SHIFT_BITS-1:0] job_shadow;
   logic                  slot_free;

   // The queue register is free now or drains on this edge.
   assign req_if.ready = slot_free;
   assign req_fire     = req_if.valid && req_if.ready;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;

   // Decode, shadow word, active channel and width registers.
   csso_cmd #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .FIELD_BITS   (FIELD_BITS),
      .SHIFT_BITS   (SHIFT_BITS)
   ) u_cmd (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .func       (req_if.func),
      .chan_num   (req_if.chan_num),
      .cap_value  (req_if.cap_value),
      .csr_fire   (csr_fire),
      .csr_index  (csr_if.index),
      .csr_data   (csr_if.data),
      .job_push   (job_push),
      .job        (job),
      .job_shadow (job_shadow)
   );

   // Queue register, step counter and output register.
   csso_seq #(
      .SHIFT_BITS (SHIFT_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .job_push        (job_push),
      .job             (job),
      .job_shadow      (job_shadow),
      .slot_free       (slot_free),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_kind        (rsp_if.kind),
      .rsp_ser_bit     (rsp_if.ser_bit),
      .rsp_shift_clk   (rsp_if.shift_clk),
      .rsp_latch_clk   (rsp_if.latch_clk),
      .rsp_chan_enable (rsp_if.chan_enable),
      .rsp_pulse_width (rsp_if.pulse_width),
      .rsp_pwm_start   (rsp_if.pwm_start),
      .rsp_last        (rsp_if.last)
   );

   // The clear pin stays released and the outputs stay enabled.
   assign rsp_if.clear_n      = 1'b1;
   assign rsp_if.out_enable_n = 1'b0;

endmodule

`default_nettype wire
